// File: sv/flpr_pkg.sv
// Shared types and constants for the fixed-length pattern rewriter.
// No dependencies; every other file but flpr_if imports this package.
package flpr_pkg;

   localparam int WIN_DEPTH = 128;   // longest pattern, window depth
   localparam int RULES     = 8;
   localparam int PTR_W     = 7;     // window / pattern offset
   localparam int RULE_W    = 3;
   localparam int FILL_W    = 8;     // holds 0..WIN_DEPTH
   localparam int CNT_W     = 4;     // rule_count register
   localparam int TBL_W     = RULE_W + PTR_W;

   typedef enum logic [1:0] {
      OP_STREAM    = 2'd0,
      OP_RULE_BYTE = 2'd1,
      OP_RULE_LEN  = 2'd2,
      OP_NONE      = 2'd3
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [7:0]          data_byte;
      logic                last;
      logic [RULE_W-1:0]   rule_index;
      logic [PTR_W-1:0]    byte_position;
      logic [7:0]          search_byte;
      logic [7:0]          replace_byte;
      logic [FILL_W-1:0]   rule_length;   // already saturated
   } cmd_type;

endpackage

// File: sv/flpr_if.sv
// Request and response channel interfaces (valid/ready words).
// Standalone; field widths follow the block's word formats.
interface flpr_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic [7:0] data_byte;
   logic       last;
   logic [2:0] rule_index;
   logic [6:0] byte_position;
   logic [7:0] search_byte;
   logic [7:0] replace_byte;
   logic [7:0] rule_length;
   modport source(output valid, operation, data_byte, last, rule_index, byte_position,
                  search_byte, replace_byte, rule_length, input ready);
   modport sink(input valid, operation, data_byte, last, rule_index, byte_position,
                search_byte, replace_byte, rule_length, output ready);
endinterface

interface flpr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_first;
   logic [7:0] byte_second;
   logic [1:0] byte_count;
   logic       run_last;
   logic       buffer_end;
   modport source(output valid, byte_first, byte_second, byte_count, run_last,
                  buffer_end, input ready);
   modport sink(input valid, byte_first, byte_second, byte_count, run_last,
                buffer_end, output ready);
endinterface

// File: sv/fixed_length_pattern_rewriter.sv
// Fixed-length pattern rewriter, top level.
// Depends on flpr_pkg, flpr_if, flpr_front, flpr_queue and flpr_back.
//
// Rewrites a byte stream with up to 8 equal-length search/replace rules of
// up to 128 bytes. Rule bytes (operation 1) and rule lengths (operation 2)
// travel on the request channel in order with stream bytes (operation 0);
// csr_write_data sets how many rules are active; the user must write it
// only while idle, which the block does not check. A stream byte joins a
// 128-byte lookahead window; once the window holds the longest active
// rule, or when the byte is marked last, the head is decided: rules in
// index order, first fitting match replaced, else one byte passes. Output
// bytes go two per response word, the final word of a request flagged
// run_last (and buffer_end for a last byte). Flow: a request word is
// taken into a register and then a 4-entry queue, so the request side
// keeps streaming while the engine works. The engine handles one word at
// a time; a rule write leaves it idle. A stream byte goes through take,
// final window check and flush, and each decision through a check, a
// step per rule tried, one more when no rule hits, an issue and a check
// per compared pattern byte and an issue and an emit per emitted byte:
// the window and table memories, read one byte per cycle with registered
// output, set that order. Response back-pressure stalls the engine when a
// full pair is waiting behind an occupied output register, and holds the
// final flush until that register frees. No clearing pass after reset.
module fixed_length_pattern_rewriter import flpr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   flpr_req_if.sink         req_bus,
   flpr_rsp_if.source       rsp_bus,
   input  logic             csr_write_enable,
   input  logic [CNT_W-1:0] csr_write_data
);
   cmd_type front_cmd;
   logic    front_valid;
   logic    front_ready;
   cmd_type queue_cmd;
   logic    queue_valid;
   logic    queue_ready;

   // classify and normalize incoming words
   flpr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .push_cmd   (front_cmd),
      .push_valid (front_valid),
      .push_ready (front_ready)
   );

   // decouples request side from engine stalls
   flpr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_cmd   (front_cmd),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .pop_cmd    (queue_cmd),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready)
   );

   // tables, window, matcher, output packing
   flpr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_cmd   (queue_cmd),
      .pop_valid (queue_valid),
      .pop_ready (queue_ready),
      .csr_we    (csr_write_enable),
      .csr_data  (csr_write_data),
      .rsp       (rsp_bus)
   );
endmodule

// File: sv/flpr_front.sv
// Front end: accepts request words, classifies and normalizes them.
// Depends on flpr_pkg and flpr_req_if.
module flpr_front import flpr_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   flpr_req_if.sink  req,
   output cmd_type   push_cmd,
   output logic      push_valid,
   input  logic      push_ready
);
   logic    valid_ff;
   cmd_type cmd_ff;
   cmd_type cmd_in;
   logic    take;

   assign req.ready  = !valid_ff || push_ready;
   assign take       = req.valid && req.ready;
   assign push_cmd   = cmd_ff;
   assign push_valid = valid_ff;

   always_comb begin
      cmd_in               = '0;
      cmd_in.op            = op_type'(req.operation);
      cmd_in.data_byte     = req.data_byte;
      cmd_in.last          = req.last;
      cmd_in.rule_index    = req.rule_index;
      cmd_in.byte_position = req.byte_position;
      cmd_in.search_byte   = req.search_byte;
      cmd_in.replace_byte  = req.replace_byte;
      // lengths past the window saturate
      cmd_in.rule_length   = (req.rule_length > FILL_W'(WIN_DEPTH)) ?
                             FILL_W'(WIN_DEPTH) : req.rule_length;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         // unknown operation is dropped here
         valid_ff <= (cmd_in.op != OP_NONE);
      end else if (push_ready) begin
         valid_ff <= 1'b0;
      end
      if (take) begin
         cmd_ff <= cmd_in;
      end
   end
endmodule

// File: sv/flpr_queue.sv
// Four-entry command queue between front end and engine.
// Depends on flpr_pkg.
module flpr_queue import flpr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cmd_type push_cmd,
   input  logic    push_valid,
   output logic    push_ready,
   output cmd_type pop_cmd,
   output logic    pop_valid,
   input  logic    pop_ready
);
   cmd_type    slot_ff [4];
   logic [1:0] wr_ff;
   logic [1:0] rd_ff;
   logic [2:0] cnt_ff;
   logic       do_push;
   logic       do_pop;

   assign push_ready = (cnt_ff != 3'd4);
   assign pop_valid  = (cnt_ff != 3'd0);
   assign pop_cmd    = slot_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) wr_ff <= wr_ff + 2'd1;
         if (do_pop)  rd_ff <= rd_ff + 2'd1;
         cnt_ff <= cnt_ff + 3'(do_push) - 3'(do_pop);
      end
      if (do_push) begin
         slot_ff[wr_ff] <= push_cmd;
      end
   end
endmodule

// File: sv/flpr_back.sv
// Engine: rule tables, lookahead window, matcher and response packer.
// Depends on flpr_pkg and flpr_rsp_if.
module flpr_back import flpr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          pop_cmd,
   input  logic             pop_valid,
   output logic             pop_ready,
   input  logic             csr_we,
   input  logic [CNT_W-1:0] csr_data,
   flpr_rsp_if.source       rsp
);
   typedef enum logic [3:0] {
      ST_IDLE, ST_CHECK, ST_RULE_SEL, ST_CMP_ISSUE, ST_CMP_CHECK,
      ST_REP_ISSUE, ST_REP_EMIT, ST_PASS_ISSUE, ST_PASS_EMIT, ST_FINISH
   } state_type;

   state_type         state_ff;
   logic [CNT_W-1:0]  rule_count_ff;
   logic [FILL_W-1:0] len_ff [RULES];
   logic [FILL_W-1:0] fill_ff;
   logic [PTR_W-1:0]  head_ff;
   logic [CNT_W-1:0]  r_ff;
   logic [PTR_W-1:0]  k_ff;
   logic              last_ff;
   logic [1:0]        hold_cnt_ff;
   logic [7:0]        hold_first_ff;
   logic [7:0]        hold_second_ff;
   logic              rsp_valid_ff;
   logic [7:0]        rsp_first_ff;
   logic [7:0]        rsp_second_ff;
   logic [1:0]        rsp_count_ff;
   logic              rsp_run_last_ff;
   logic              rsp_buf_end_ff;

   logic [7:0] win_mem  [WIN_DEPTH];
   logic [7:0] srch_mem [RULES*WIN_DEPTH];
   logic [7:0] rep_mem  [RULES*WIN_DEPTH];
   logic [7:0] win_q_ff;
   logic [7:0] srch_q_ff;
   logic [7:0] rep_q_ff;

   logic [CNT_W-1:0]  active;
   logic [FILL_W-1:0] longest;
   logic [FILL_W-1:0] len_sel;
   logic              last_k;
   logic [PTR_W-1:0]  win_addr;
   logic [TBL_W-1:0]  tbl_addr;
   logic              take;
   logic              out_busy;
   logic              can_emit;
   logic              emit_en;
   logic [7:0]        emit_data;
   logic              rsp_load;

   assign active = (rule_count_ff > CNT_W'(RULES)) ? CNT_W'(RULES) : rule_count_ff;

   always_comb begin
      longest = '0;
      for (int i = 0; i < RULES; i++) begin
         if (CNT_W'(i) < active && len_ff[i] > longest) longest = len_ff[i];
      end
   end

   assign len_sel   = len_ff[r_ff[RULE_W-1:0]];
   assign last_k    = ({1'b0, k_ff} == len_sel - FILL_W'(1));
   assign win_addr  = head_ff + k_ff;
   assign tbl_addr  = {r_ff[RULE_W-1:0], k_ff};
   assign pop_ready = (state_ff == ST_IDLE);
   assign take      = pop_valid && pop_ready;
   assign out_busy  = rsp_valid_ff && !rsp.ready;
   assign can_emit  = (hold_cnt_ff != 2'd2) || !out_busy;
   assign emit_en   = can_emit &&
                      (state_ff == ST_REP_EMIT || state_ff == ST_PASS_EMIT);
   assign emit_data = (state_ff == ST_REP_EMIT) ? rep_q_ff : win_q_ff;
   // output register loads a new word this cycle
   assign rsp_load  = (emit_en && hold_cnt_ff == 2'd2) ||
                      (state_ff == ST_FINISH && hold_cnt_ff != 2'd0 && !out_busy);

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.byte_first  = rsp_first_ff;
   assign rsp.byte_second = rsp_second_ff;
   assign rsp.byte_count  = rsp_count_ff;
   assign rsp.run_last    = rsp_run_last_ff;
   assign rsp.buffer_end  = rsp_buf_end_ff;

   // window: write at tail, one registered read
   always_ff @(posedge clock) begin
      if (take && pop_cmd.op == OP_STREAM && fill_ff < FILL_W'(WIN_DEPTH)) begin
         win_mem[head_ff + fill_ff[PTR_W-1:0]] <= pop_cmd.data_byte;
      end
      win_q_ff <= win_mem[win_addr];
   end

   // rule tables
   always_ff @(posedge clock) begin
      if (take && pop_cmd.op == OP_RULE_BYTE) begin
         srch_mem[{pop_cmd.rule_index, pop_cmd.byte_position}] <= pop_cmd.search_byte;
         rep_mem[{pop_cmd.rule_index, pop_cmd.byte_position}]  <= pop_cmd.replace_byte;
      end
      srch_q_ff <= srch_mem[tbl_addr];
      rep_q_ff  <= rep_mem[tbl_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rule_count_ff <= '0;
         for (int i = 0; i < RULES; i++) len_ff[i] <= '0;
         fill_ff       <= '0;
         head_ff       <= '0;
         r_ff          <= '0;
         k_ff          <= '0;
         last_ff       <= 1'b0;
         hold_cnt_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) rule_count_ff <= csr_data;
         if (rsp_valid_ff && rsp.ready && !rsp_load) rsp_valid_ff <= 1'b0;

         unique case (state_ff)
            ST_IDLE: begin
               if (take) begin
                  unique case (pop_cmd.op)
                     OP_STREAM: begin
                        if (fill_ff < FILL_W'(WIN_DEPTH)) fill_ff <= fill_ff + FILL_W'(1);
                        last_ff  <= pop_cmd.last;
                        state_ff <= ST_CHECK;
                     end
                     OP_RULE_LEN: len_ff[pop_cmd.rule_index] <= pop_cmd.rule_length;
                     default: ;   // byte pair goes to the table memories
                  endcase
               end
            end
            ST_CHECK: begin
               if (fill_ff != '0 && (last_ff || fill_ff >= longest)) begin
                  r_ff     <= '0;
                  state_ff <= ST_RULE_SEL;
               end else begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_RULE_SEL: begin
               k_ff <= '0;
               if (r_ff >= active) begin
                  state_ff <= ST_PASS_ISSUE;
               end else if (len_sel == '0 || len_sel > fill_ff) begin
                  r_ff <= r_ff + CNT_W'(1);
               end else begin
                  state_ff <= ST_CMP_ISSUE;
               end
            end
            ST_CMP_ISSUE: state_ff <= ST_CMP_CHECK;
            ST_CMP_CHECK: begin
               if (win_q_ff != srch_q_ff) begin
                  r_ff     <= r_ff + CNT_W'(1);
                  state_ff <= ST_RULE_SEL;
               end else if (last_k) begin
                  k_ff     <= '0;
                  state_ff <= ST_REP_ISSUE;
               end else begin
                  k_ff     <= k_ff + PTR_W'(1);
                  state_ff <= ST_CMP_ISSUE;
               end
            end
            ST_REP_ISSUE: state_ff <= ST_REP_EMIT;
            ST_REP_EMIT: begin
               if (can_emit) begin
                  if (last_k) begin
                     head_ff  <= head_ff + len_sel[PTR_W-1:0];
                     fill_ff  <= fill_ff - len_sel;
                     state_ff <= ST_CHECK;
                  end else begin
                     k_ff     <= k_ff + PTR_W'(1);
                     state_ff <= ST_REP_ISSUE;
                  end
               end
            end
            ST_PASS_ISSUE: state_ff <= ST_PASS_EMIT;
            ST_PASS_EMIT: begin
               if (can_emit) begin
                  head_ff  <= head_ff + PTR_W'(1);
                  fill_ff  <= fill_ff - FILL_W'(1);
                  state_ff <= ST_CHECK;
               end
            end
            ST_FINISH: begin
               if (hold_cnt_ff == 2'd0) begin
                  state_ff <= ST_IDLE;
               end else if (!out_busy) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_first_ff    <= hold_first_ff;
                  rsp_second_ff   <= hold_second_ff;
                  rsp_count_ff    <= hold_cnt_ff;
                  rsp_run_last_ff <= 1'b1;
                  rsp_buf_end_ff  <= last_ff;
                  hold_cnt_ff     <= '0;
                  state_ff        <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase

         // packer: here a full pair leaves only when another byte follows it; the final flush sends what is held
         if (emit_en) begin
            if (hold_cnt_ff == 2'd2) begin
               rsp_valid_ff    <= 1'b1;
               rsp_first_ff    <= hold_first_ff;
               rsp_second_ff   <= hold_second_ff;
               rsp_count_ff    <= 2'd2;
               rsp_run_last_ff <= 1'b0;
               rsp_buf_end_ff  <= 1'b0;
            end
            if (hold_cnt_ff == 2'd1) begin
               hold_second_ff <= emit_data;
               hold_cnt_ff    <= 2'd2;
            end else begin
               hold_first_ff  <= emit_data;
               hold_second_ff <= '0;
               hold_cnt_ff    <= 2'd1;
            end
         end
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(WIN_DEPTH))
      else $error("window fill past depth");
   a_single_is_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_count_ff == 2'd1 |-> rsp_run_last_ff)
      else $error("single-byte word not final");
   a_cmp_fits: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CMP_ISSUE |-> len_sel != '0 && len_sel <= fill_ff)
      else $error("compare on a rule that does not fit");
   a_hold_range: assert property (@(posedge clock) disable iff (reset)
      hold_cnt_ff != 2'd3)
      else $error("packer count out of range");
   a_consume_fill: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PASS_EMIT |-> fill_ff != '0)
      else $error("pass with empty window");
endmodule
